// ===== rtl/mfb_pkg.sv =====
package mfb_pkg;

  localparam int WORD_BITS  = 64;
  localparam int COLOR_BITS = 16;

  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_RECT    = 3'd1;
  localparam logic [2:0] CMD_FILL    = 3'd2;
  localparam logic [2:0] CMD_ERASE   = 3'd3;
  localparam logic [2:0] CMD_PRESENT = 3'd4;

  typedef enum logic [9:0] {
    ST_INIT = 10'b00_0000_0001,
    ST_IDLE = 10'b00_0000_0010,
    ST_CLR  = 10'b00_0000_0100,
    ST_ROW  = 10'b00_0000_1000,
    ST_SQ   = 10'b00_0001_0000,
    ST_RD   = 10'b00_0010_0000,
    ST_WR   = 10'b00_0100_0000,
    ST_PRD  = 10'b00_1000_0000,
    ST_PLAT = 10'b01_0000_0000,
    ST_EMIT = 10'b10_0000_0000
  } state_t;

endpackage

// ===== rtl/mfb_ram.sv =====
module mfb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/mono_framebuffer_shape_fill_diff_core.sv =====
// Two 128-column one-bit frames (current and previous), one 64-bit word per
// half row, each in its own single-port RAM. After reset the block sweeps
// both RAMs to zero with busy high. Clear zeroes the current frame only.
// Rectangle and circle fills and erases walk the covered rows; each in-frame
// row is checked (ST_ROW), then each of its two words is read (ST_RD) and
// written back (ST_WR); a circle row first finds its span with a 6-step
// square root (ST_SQ). Rows outside the frame, or outside the circle, are
// skipped. Present reads the two words, then scans the difference one bit
// per cycle and stops after the last changed bit; the last write shows in
// the first cycle with busy low. Pixel writes come out on out_strobe at most
// one per cycle and cannot be stalled; out_last marks the final write of
// the word.
module mono_framebuffer_shape_fill_diff_core #(
  parameter int FRAME_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_pos_x,
  input  logic [7:0]  in_pos_y,
  input  logic [7:0]  in_span_width,
  input  logic [7:0]  in_span_height,
  input  logic [5:0]  in_radius,
  input  logic [7:0]  in_word_index,
  output logic        out_strobe,
  output logic [6:0]  out_pixel_x,
  output logic [6:0]  out_pixel_y,
  output logic [15:0] out_pixel_color,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int AW   = $clog2(FRAME_WORDS);
  localparam int ROWS = FRAME_WORDS / 2;
  localparam int WB   = mfb_pkg::WORD_BITS;

  mfb_pkg::state_t state_r, state_nxt;

  logic [2:0]  cmd_r, cmd_nxt;
  logic [7:0]  px_r, px_nxt;
  logic [7:0]  py_r, py_nxt;
  logic [7:0]  sw_r, sw_nxt;
  logic [7:0]  wi_r, wi_nxt;
  logic signed [10:0] y_r, y_nxt;
  logic signed [10:0] y_end_r, y_end_nxt;
  logic        half_r, half_nxt;
  logic [11:0] r2_r, r2_nxt;
  logic [11:0] t_r, t_nxt;
  logic [5:0]  m_r, m_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [WB-1:0] diff_r, diff_nxt;
  logic [WB-1:0] cur_r, cur_nxt;
  logic [5:0]  j_r, j_nxt;
  logic [15:0] color_r;

  logic        out_strobe_r, out_strobe_nxt;
  logic        out_last_r, out_last_nxt;
  logic [6:0]  out_x_r, out_x_nxt;
  logic [6:0]  out_y_r, out_y_nxt;
  logic [15:0] out_color_r, out_color_nxt;

  logic          cur_we, prev_we;
  logic [AW-1:0] cur_addr, prev_addr;
  logic [WB-1:0] cur_wdata, prev_wdata;
  logic [WB-1:0] cur_rdata, prev_rdata;

  logic [10:0]   word_full;
  logic [AW-1:0] word_addr;
  logic [AW-1:0] wi_addr;
  logic [WB-1:0] mask;
  logic signed [9:0] lo, hi;
  logic is_rect;

  assign is_rect   = (cmd_r == mfb_pkg::CMD_RECT);
  assign word_full = {y_r[9:0], half_r};
  assign word_addr = word_full[AW-1:0];
  assign wi_addr   = AW'({2'b00, wi_r});

  mfb_ram #(.WIDTH(WB), .DEPTH(FRAME_WORDS)) u_cur_ram (
    .clk(clk), .we(cur_we), .addr(cur_addr), .wdata(cur_wdata), .rdata(cur_rdata)
  );

  mfb_ram #(.WIDTH(WB), .DEPTH(FRAME_WORDS)) u_prev_ram (
    .clk(clk), .we(prev_we), .addr(prev_addr), .wdata(prev_wdata), .rdata(prev_rdata)
  );

  // column span of the current row: rectangle bounds or circle chord
  always_comb begin
    logic signed [9:0] c;
    if (is_rect) begin
      lo = $signed({2'b00, px_r});
      hi = $signed({2'b00, px_r}) + $signed({2'b00, sw_r});
    end else begin
      lo = $signed({2'b00, px_r}) - $signed({4'b0000, m_r});
      hi = $signed({2'b00, px_r}) + $signed({4'b0000, m_r}) + 10'sd1;
    end
    for (int j = 0; j < WB; j++) begin
      c = $signed({3'b000, half_r, 6'(j)});
      mask[WB-1-j] = (c >= lo) && (c < hi);
    end
  end

  always_comb begin
    logic signed [10:0] dy_full;
    logic signed [7:0]  dy;
    logic signed [15:0] dysq;
    logic signed [15:0] t_full;
    logic [5:0]  cand;
    logic [11:0] cand_sq;

    state_nxt = state_r;
    cmd_nxt = cmd_r;   px_nxt = px_r;     py_nxt = py_r;   sw_nxt = sw_r;
    wi_nxt = wi_r;     y_nxt = y_r;       y_end_nxt = y_end_r;
    half_nxt = half_r; r2_nxt = r2_r;     t_nxt = t_r;     m_nxt = m_r;
    bit_nxt = bit_r;   addr_nxt = addr_r; diff_nxt = diff_r;
    cur_nxt = cur_r;   j_nxt = j_r;
    out_strobe_nxt = 1'b0;
    out_last_nxt   = 1'b0;
    out_x_nxt = out_x_r; out_y_nxt = out_y_r; out_color_nxt = out_color_r;

    cur_we = 1'b0;  cur_addr = word_addr;  cur_wdata = '0;
    prev_we = 1'b0; prev_addr = word_addr; prev_wdata = '0;

    dy_full = y_r - $signed({3'b000, py_r});
    dy      = dy_full[7:0];
    dysq    = dy * dy;
    t_full  = $signed({4'b0000, r2_r}) - dysq;
    cand    = m_r | (6'd1 << bit_r);
    cand_sq = {6'd0, cand} * {6'd0, cand};

    case (state_r)
      mfb_pkg::ST_INIT: begin
        cur_we = 1'b1;  cur_addr = addr_r;
        prev_we = 1'b1; prev_addr = addr_r;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(FRAME_WORDS - 1)) begin
          state_nxt = mfb_pkg::ST_IDLE;
        end
      end
      mfb_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          px_nxt  = in_pos_x;
          py_nxt  = in_pos_y;
          sw_nxt  = in_span_width;
          wi_nxt  = in_word_index;
          r2_nxt  = {6'd0, in_radius} * {6'd0, in_radius};
          half_nxt = 1'b0;
          addr_nxt = '0;
          case (in_command)
            mfb_pkg::CMD_CLEAR: state_nxt = mfb_pkg::ST_CLR;
            mfb_pkg::CMD_RECT: begin
              y_nxt     = $signed({3'b000, in_pos_y});
              y_end_nxt = $signed({3'b000, in_pos_y}) + $signed({3'b000, in_span_height});
              state_nxt = mfb_pkg::ST_ROW;
            end
            mfb_pkg::CMD_FILL, mfb_pkg::CMD_ERASE: begin
              y_nxt     = $signed({3'b000, in_pos_y}) - $signed({5'b00000, in_radius});
              y_end_nxt = $signed({3'b000, in_pos_y}) + $signed({5'b00000, in_radius});
              state_nxt = mfb_pkg::ST_ROW;
            end
            mfb_pkg::CMD_PRESENT: begin
              if ({3'b000, in_word_index} < 11'(FRAME_WORDS)) begin
                state_nxt = mfb_pkg::ST_PRD;
              end
            end
            default: state_nxt = mfb_pkg::ST_IDLE;
          endcase
        end
      end
      mfb_pkg::ST_CLR: begin
        cur_we = 1'b1; cur_addr = addr_r;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(FRAME_WORDS - 1)) begin
          state_nxt = mfb_pkg::ST_IDLE;
        end
      end
      mfb_pkg::ST_ROW: begin
        half_nxt = 1'b0;
        if (y_r >= y_end_r) begin
          state_nxt = mfb_pkg::ST_IDLE;
        end else if (y_r < 11'sd0 || y_r >= 11'(ROWS)) begin
          y_nxt = y_r + 11'sd1;
        end else if (is_rect) begin
          state_nxt = mfb_pkg::ST_RD;
        end else if (t_full > 16'sd0) begin
          t_nxt = t_full[11:0];
          m_nxt = '0;
          bit_nxt = 3'd5;
          state_nxt = mfb_pkg::ST_SQ;
        end else begin
          y_nxt = y_r + 11'sd1;
        end
      end
      mfb_pkg::ST_SQ: begin
        // largest m with m*m < t, one result bit per cycle
        if (cand_sq < t_r) begin
          m_nxt = cand;
        end
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          state_nxt = mfb_pkg::ST_RD;
        end
      end
      mfb_pkg::ST_RD: begin
        state_nxt = mfb_pkg::ST_WR;
      end
      mfb_pkg::ST_WR: begin
        cur_we = 1'b1;
        cur_wdata = (cmd_r == mfb_pkg::CMD_ERASE) ? (cur_rdata & ~mask) : (cur_rdata | mask);
        prev_we = is_rect;
        prev_wdata = prev_rdata & ~mask;
        if (!half_r) begin
          half_nxt = 1'b1;
          state_nxt = mfb_pkg::ST_RD;
        end else begin
          y_nxt = y_r + 11'sd1;
          state_nxt = mfb_pkg::ST_ROW;
        end
      end
      mfb_pkg::ST_PRD: begin
        cur_addr = wi_addr; prev_addr = wi_addr;
        state_nxt = mfb_pkg::ST_PLAT;
      end
      mfb_pkg::ST_PLAT: begin
        prev_we = 1'b1; prev_addr = wi_addr; prev_wdata = cur_rdata;
        cur_addr = wi_addr;
        cur_nxt = cur_rdata;
        diff_nxt = cur_rdata ^ prev_rdata;
        j_nxt = '0;
        state_nxt = mfb_pkg::ST_EMIT;
      end
      mfb_pkg::ST_EMIT: begin
        out_strobe_nxt = diff_r[WB-1];
        out_last_nxt   = diff_r[WB-1] && (diff_r[WB-2:0] == '0);
        out_x_nxt      = {wi_r[0], j_r};
        out_y_nxt      = wi_r[7:1];
        out_color_nxt  = cur_r[WB-1] ? color_r : 16'd0;
        diff_nxt = {diff_r[WB-2:0], 1'b0};
        cur_nxt  = {cur_r[WB-2:0], 1'b0};
        j_nxt    = j_r + 6'd1;
        if (diff_r[WB-2:0] == '0) begin
          state_nxt = mfb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mfb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mfb_pkg::ST_INIT;
      addr_r       <= '0;
      color_r      <= 16'hFFFF;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_last_r   <= out_last_nxt;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;   px_r <= px_nxt;     py_r <= py_nxt;   sw_r <= sw_nxt;
    wi_r <= wi_nxt;     y_r <= y_nxt;       y_end_r <= y_end_nxt;
    half_r <= half_nxt; r2_r <= r2_nxt;     t_r <= t_nxt;     m_r <= m_nxt;
    bit_r <= bit_nxt;   diff_r <= diff_nxt; cur_r <= cur_nxt; j_r <= j_nxt;
    out_x_r <= out_x_nxt; out_y_r <= out_y_nxt; out_color_r <= out_color_nxt;
  end

  assign busy            = (state_r != mfb_pkg::ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_last        = out_last_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;

  a_strobe_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == mfb_pkg::ST_EMIT))
    else $error("pixel write outside present scan");

  a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_strobe_r)
    else $error("last flag without pixel write");

  a_prev_only_rect: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfb_pkg::ST_WR && !is_rect) |-> !prev_we)
    else $error("previous frame written by circle command");

  a_scan_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_last_nxt && state_r == mfb_pkg::ST_EMIT) |=> (state_r == mfb_pkg::ST_IDLE))
    else $error("scan continued past last changed pixel");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam int NWORDS = 256;
  localparam int NROWS  = NWORDS / 2;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_command;
  logic [7:0]  in_pos_x, in_pos_y, in_span_width, in_span_height, in_word_index;
  logic [5:0]  in_radius;
  logic        out_strobe;
  logic [6:0]  out_pixel_x, out_pixel_y;
  logic [15:0] out_pixel_color;
  logic        out_last;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  mono_framebuffer_shape_fill_diff_core #(.FRAME_WORDS(NWORDS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_span_width(in_span_width), .in_span_height(in_span_height),
    .in_radius(in_radius), .in_word_index(in_word_index),
    .out_strobe(out_strobe), .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_pixel_color(out_pixel_color), .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  typedef struct packed {
    logic [6:0]  px;
    logic [6:0]  py;
    logic [15:0] color;
    logic        last;
  } pixel_wr_t;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] x, y, w, h;
    logic [5:0] r;
    logic [7:0] widx;
    int         n_known;   // -1: use predictor only
    pixel_wr_t  first_wr;
  } cmd_row_t;

  logic [63:0] cur_fb [NWORDS];
  logic [63:0] prev_fb [NWORDS];
  logic [15:0] ink;
  pixel_wr_t   pending_wr[$];
  int          errors, cycles, n_cmds, n_writes;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void set_px(int x, int y, bit val, bit clr_prev);
    int a;
    if (x < 0 || x > 127 || y < 0 || y >= NROWS) return;
    a = y * 2 + x / 64;
    cur_fb[a][63 - (x % 64)] = val;
    if (clr_prev) prev_fb[a][63 - (x % 64)] = 1'b0;
  endfunction

  // updates the frame model and queues the pixel writes a command produces
  function automatic int apply_cmd(cmd_row_t c);
    int n;
    int cx, cy, rr;
    logic [63:0] diff;
    pixel_wr_t wr;
    n = 0;
    cx = c.x; cy = c.y; rr = c.r;
    case (c.cmd)
      mfb_pkg::CMD_CLEAR: for (int i = 0; i < NWORDS; i++) cur_fb[i] = '0;
      mfb_pkg::CMD_RECT:
        for (int yy = c.y; yy < int'(c.y) + int'(c.h); yy++)
          for (int xx = c.x; xx < int'(c.x) + int'(c.w); xx++)
            set_px(xx, yy, 1'b1, 1'b1);
      mfb_pkg::CMD_FILL, mfb_pkg::CMD_ERASE:
        for (int yy = cy - rr; yy < cy + rr; yy++)
          for (int xx = cx - rr; xx < cx + rr; xx++)
            if ((xx - cx) * (xx - cx) + (yy - cy) * (yy - cy) < rr * rr)
              set_px(xx, yy, c.cmd == mfb_pkg::CMD_FILL, 1'b0);
      mfb_pkg::CMD_PRESENT: if (c.widx < NWORDS) begin
        diff = cur_fb[c.widx] ^ prev_fb[c.widx];
        for (int j = 0; j < 64; j++)
          if (diff[63 - j]) begin
            wr.px = 7'((c.widx % 2) * 64 + j);
            wr.py = 7'(c.widx / 2);
            wr.color = cur_fb[c.widx][63 - j] ? ink : 16'h0;
            wr.last = 1'b0;
            pending_wr.push_back(wr);
            n++;
          end
        if (n > 0) pending_wr[$].last = 1'b1;
        prev_fb[c.widx] = cur_fb[c.widx];
      end
      default: ;
    endcase
    return n;
  endfunction

  always @(posedge clk) begin
    pixel_wr_t want, got;
    if (rst_n && out_strobe) begin
      got = '{out_pixel_x, out_pixel_y, out_pixel_color, out_last};
      n_writes++;
      if (pending_wr.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel write x=%0d y=%0d c=%h last=%b", $time,
                 got.px, got.py, got.color, got.last);
      end else begin
        want = pending_wr.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: pixel write mismatch exp x=%0d y=%0d c=%h last=%b", $time,
                   want.px, want.py, want.color, want.last);
          $display("%0t:                      got x=%0d y=%0d c=%h last=%b", $time,
                   got.px, got.py, got.color, got.last);
        end
      end
    end
  end

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic random_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return;
    else if (k < 92) idle_cycles($urandom_range(1, 4));
    else idle_cycles($urandom_range(20, 120));
  endtask

  // start stays high after the accepting edge; the next gap or command
  // decides what it does next
  task automatic issue_cmd(cmd_row_t c);
    int n;
    in_command <= c.cmd; in_pos_x <= c.x; in_pos_y <= c.y;
    in_span_width <= c.w; in_span_height <= c.h; in_radius <= c.r;
    in_word_index <= c.widx;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_cmds++;
    if (c.n_known >= 0) begin
      n = pending_wr.size();
      if (apply_cmd(c) != c.n_known) begin
        errors++;
        $display("%0t: directed row cmd=%0d word=%0d expected %0d writes, predictor %0d",
                 $time, c.cmd, c.widx, c.n_known, pending_wr.size() - n);
      end else if (c.n_known > 0 && pending_wr[n] !== c.first_wr) begin
        errors++;
        $display("%0t: directed row first write exp %h pred %h", $time,
                 c.first_wr, pending_wr[n]);
      end
    end else void'(apply_cmd(c));
  endtask

  // lets the block finish and drain before a register write
  task automatic settle();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while ((busy || pending_wr.size() != 0) && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    idle_cycles(80);
  endtask

  task automatic write_ink(logic [15:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ink = v;
  endtask

  function automatic cmd_row_t mk(logic [2:0] cmd, int x, int y, int w, int h, int r,
                                  int widx, int n = -1, pixel_wr_t f = '0);
    cmd_row_t c;
    c.cmd = cmd; c.x = 8'(x); c.y = 8'(y); c.w = 8'(w); c.h = 8'(h);
    c.r = 6'(r); c.widx = 8'(widx); c.n_known = n; c.first_wr = f;
    return c;
  endfunction

  function automatic cmd_row_t rand_cmd();
    cmd_row_t c;
    int k;
    c = mk(3'($urandom_range(0, 7)), $urandom_range(0, 255), $urandom_range(0, 255),
           $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 63),
           $urandom_range(0, 255));
    k = $urandom_range(0, 99);
    // mostly small shapes near the frame and presents of words in rows 0 to 63
    if (k < 35) begin
      c.cmd = mfb_pkg::CMD_PRESENT;
      c.widx = 8'($urandom_range(0, 127));
    end else if (k < 55) begin
      c.cmd = mfb_pkg::CMD_RECT;
      c.x = 8'($urandom_range(0, 140)); c.y = 8'($urandom_range(0, 70));
      c.w = 8'($urandom_range(0, 20)); c.h = 8'($urandom_range(0, 6));
    end else if (k < 75) begin
      c.cmd = $urandom_range(0, 1) ? mfb_pkg::CMD_FILL : mfb_pkg::CMD_ERASE;
      c.x = 8'($urandom_range(0, 140)); c.y = 8'($urandom_range(0, 70));
      c.r = 6'($urandom_range(0, 8));
    end else if (k < 80) c.cmd = mfb_pkg::CMD_CLEAR;
    else if (k < 85) begin
      // rectangle, fill or erase with random position, width and radius, height 0 to 12
      c.cmd = 3'($urandom_range(mfb_pkg::CMD_RECT, mfb_pkg::CMD_ERASE));
      c.h = 8'($urandom_range(0, 12));
    end
    return c;
  endfunction

  cmd_row_t dir_rows[$];

  initial begin
    cmd_row_t c;
    rst_n = 1'b0; start = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
    in_command = '0; in_pos_x = '0; in_pos_y = '0; in_span_width = '0;
    in_span_height = '0; in_radius = '0; in_word_index = '0;
    errors = 0; cycles = 0; n_cmds = 0; n_writes = 0; ink = 16'hFFFF;
    for (int i = 0; i < NWORDS; i++) begin
      cur_fb[i] = '0; prev_fb[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      mk(mfb_pkg::CMD_PRESENT, 0, 0, 0, 0, 0, 0, 0),
      mk(mfb_pkg::CMD_RECT, 0, 0, 1, 1, 0, 0, 0),
      mk(mfb_pkg::CMD_PRESENT, 0, 0, 0, 0, 0, 0, 1, '{7'd0, 7'd0, 16'hFFFF, 1'b1}),
      mk(mfb_pkg::CMD_RECT, 0, 1, 128, 1, 0, 0, 0),
      mk(mfb_pkg::CMD_PRESENT, 0, 0, 0, 0, 0, 2, 64, '{7'd0, 7'd1, 16'hFFFF, 1'b0}),
      mk(mfb_pkg::CMD_PRESENT, 0, 0, 0, 0, 0, 3, 64, '{7'd64, 7'd1, 16'hFFFF, 1'b0}),
      mk(mfb_pkg::CMD_PRESENT, 0, 0, 0, 0, 0, 3, 0),
      mk(mfb_pkg::CMD_RECT, 255, 255, 255, 255, 0, 0, 0),
      mk(mfb_pkg::CMD_RECT, 120, 125, 255, 255, 0, 0, 0),
      mk(mfb_pkg::CMD_RECT, 10, 10, 0, 5, 0, 0, 0),
      mk(mfb_pkg::CMD_FILL, 64, 64, 0, 0, 0, 0, 0),
      mk(mfb_pkg::CMD_FILL, 0, 0, 0, 0, 63, 0, 0),
      mk(mfb_pkg::CMD_ERASE, 127, 127, 0, 0, 63, 0, 0),
      mk(mfb_pkg::CMD_FILL, 255, 255, 0, 0, 63, 0, 0),
      mk(mfb_pkg::CMD_ERASE, 0, 0, 0, 0, 1, 0, 0),
      mk(mfb_pkg::CMD_PRESENT, 0, 0, 0, 0, 0, 255, 0),
      mk(mfb_pkg::CMD_PRESENT, 0, 0, 0, 0, 0, 254),
      mk(mfb_pkg::CMD_PRESENT, 0, 0, 0, 0, 0, 1),
      mk(mfb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0),
      mk(mfb_pkg::CMD_PRESENT, 0, 0, 0, 0, 0, 2, 64, '{7'd0, 7'd1, 16'h0000, 1'b0}),
      mk(3'd5, 255, 255, 255, 255, 63, 255, 0),
      mk(3'd6, 0, 0, 0, 0, 0, 0, 0),
      mk(3'd7, 170, 85, 85, 170, 42, 85, 0)
    };
    foreach (dir_rows[i]) begin
      issue_cmd(dir_rows[i]);
      random_gap();
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_ink(16'h0000);
        1: write_ink(16'hFFFF);
        2: write_ink(16'hA5A5);
        default: write_ink(16'($urandom()));
      endcase
      for (int i = 0; i < 27; i++) begin
        c = rand_cmd();
        issue_cmd(c);
        if (i == 13) settle();
        else if (i % 9 > 3) random_gap();
      end
    end

    settle();
    $display("%0d commands over 4 colors, %0d pixel writes checked", n_cmds, n_writes);
    if (errors == 0 && pending_wr.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors, %0d writes missing", errors, pending_wr.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
